FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VMU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define VMU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/vmu_pkg.sv
`default_nettype none
package vmu_pkg;

	localparam int W  = 32;          // component width
	localparam int F  = 16;          // fraction bits
	localparam int PW = 2 * W;       // product width
	localparam int SW = 2 * W + 2;   // width of sums of products
	localparam int NW = W + F;       // divider numerator width

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_SCALE  = 4'd2,
		OP_DIVIDE = 4'd3,
		OP_DOT    = 4'd4,
		OP_CROSS  = 4'd5,
		OP_MAG    = 4'd6,
		OP_NORM   = 4'd7,
		OP_PERP   = 4'd8
	} func_t;

	typedef logic [W-1:0] comp_t;

	typedef struct packed {
		comp_t val;
		logic  sat;
	} nar_t;

	typedef struct packed {
		func_t             op;
		logic [2:0][W-1:0] v;
		comp_t             scalar;
		comp_t             f;
		logic              sat;
		logic              dz;
	} carry_t;

	// Saturate a sign and magnitude pair to the signed component range.
	function automatic nar_t clip_mag(input logic neg, input logic [SW-1:0] mag);
		logic [SW-1:0] lim;
		logic [SW-1:0] m;
		nar_t r;
		lim = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}} + SW'(neg);
		m = mag;
		r.sat = 1'b0;
		if (mag > lim) begin
			m = lim;
			r.sat = 1'b1;
		end
		r.val = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
		return r;
	endfunction

	// Optional shift right toward zero, then saturate.
	function automatic nar_t narrow(input logic signed [SW-1:0] v, input logic shr);
		logic [SW-1:0] mag;
		mag = v[SW-1] ? (~v + 1'b1) : v;
		if (shr) begin
			mag = mag >> F;
		end
		return clip_mag(v[SW-1], mag);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vector3_math_unit_core.sv
// Channel   Dir  tvalid/tready          tdata / tuser
// s_axis    in   s_axis_tvalid/tready   ax ay az bx by bz factor / func
// m_axis    out  m_axis_tvalid/tready   rx ry rz scalar_out / div_zero saturated
//
// One transaction is taken every cycle unless a held output stalls the pipeline.
// Most of the pipeline depth comes from the 32-step square root pipeline and the 48-step divider lanes.
// A held output with valid data freezes the whole pipeline; input ready follows that stall.
// Reset clears only the stage valid bits.
`default_nettype none
`include "assert_macros.svh"
module vector3_math_unit_core import vmu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// ax, ay, az, bx, by, bz, factor from the lowest bit up
	input  logic [7*W-1:0]  s_axis_tdata,
	// func
	input  logic [3:0]      s_axis_tuser,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// rx, ry, rz, scalar_out from the lowest bit up
	output logic [4*W-1:0]  m_axis_tdata,
	// div_zero, saturated from the lowest bit up
	output logic [1:0]      m_axis_tuser
);

	localparam int L = 6 + W + 1 + NW + 1;

	logic         en;
	logic [L-1:0] vld_q;

	assign en            = !vld_q[L-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_axis_tvalid};
		end
	end

	// Input stage, with the perpendicular helper vector formed on the way in.
	logic [2:0][W-1:0] in_a, in_b, in_t;
	logic [1:0]        min_idx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_a[i] = s_axis_tdata[i*W +: W];
			in_b[i] = s_axis_tdata[(i+3)*W +: W];
		end
		if ($signed(in_a[0]) < $signed(in_a[1])) begin
			min_idx = ($signed(in_a[0]) < $signed(in_a[2])) ? 2'd0 : 2'd2;
		end else begin
			min_idx = ($signed(in_a[1]) < $signed(in_a[2])) ? 2'd1 : 2'd2;
		end
		in_t = in_a;
		in_t[min_idx] = W'(1) << F;
	end

	func_t             op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [2:0][W-1:0] a_s1, b_s1, t_s1;
	comp_t             f_s1, f_s2, f_s3, f_s4, f_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= func_t'(s_axis_tuser);
			a_s1  <= in_a;
			b_s1  <= in_b;
			t_s1  <= in_t;
			f_s1  <= s_axis_tdata[6*W +: W];
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			op_s4 <= op_s3;
			f_s2  <= f_s1;
			f_s3  <= f_s2;
			f_s4  <= f_s3;
		end
	end

	logic [2:0][W-1:0]  lv_s4;
	logic [2:0][PW-1:0] lsq_s4;
	logic [2:0][PW-1:0] ldp_s4;
	logic [2:0]         lsat_s4;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vmu_lane u_lane (
			.clk    (clk),
			.en     (en),
			.op     (op_s1),
			.ai     (a_s1[i]),
			.bi     (b_s1[i]),
			.a1     (a_s1[(i+1)%3]),
			.a2     (a_s1[(i+2)%3]),
			.b1     (b_s1[(i+1)%3]),
			.b2     (b_s1[(i+2)%3]),
			.t1     (t_s1[(i+1)%3]),
			.t2     (t_s1[(i+2)%3]),
			.f      (f_s1),
			.v_s4   (lv_s4[i]),
			.sq_s4  (lsq_s4[i]),
			.dp_s4  (ldp_s4[i]),
			.sat_s4 (lsat_s4[i])
		);
	end

	// Merge the lanes: sum of squares and dot product over two stages.
	logic [PW:0]          sqa_s5;
	logic [PW-1:0]        sq2_s5;
	logic signed [SW-1:0] dota_s5;
	logic [PW-1:0]        dp2_s5;
	logic [2:0][W-1:0]    v_s5;
	logic                 sat_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s5  <= {1'b0, lsq_s4[0]} + {1'b0, lsq_s4[1]};
			sq2_s5  <= lsq_s4[2];
			dota_s5 <= SW'($signed(ldp_s4[0])) + SW'($signed(ldp_s4[1]));
			dp2_s5  <= ldp_s4[2];
			v_s5    <= lv_s4;
			sat_s5  <= |lsat_s4;
			op_s5   <= op_s4;
			f_s5    <= f_s4;
		end
	end

	carry_t        c_nx, c_s6;
	logic [PW-1:0] rad_s6;

	always_comb begin
		nar_t dn;
		dn = narrow(dota_s5 + SW'($signed(dp2_s5)), 1'b1);
		c_nx.op     = op_s5;
		c_nx.v      = v_s5;
		c_nx.f      = f_s5;
		c_nx.dz     = 1'b0;
		c_nx.scalar = (op_s5 == OP_DOT) ? dn.val : '0;
		c_nx.sat    = sat_s5 || ((op_s5 == OP_DOT) && dn.sat);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6   <= c_nx;
			rad_s6 <= PW'(sqa_s5 + {1'b0, sq2_s5});
		end
	end

	logic [W-1:0] root;
	carry_t       sc_q [1:W];

	vmu_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s6),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sc_q[1] <= c_s6;
			for (int k = 1; k < W; k++) begin
				sc_q[k+1] <= sc_q[k];
			end
		end
	end

	// Pick the divisor and set up the numerators for the divider lanes.
	carry_t             cd_nx, c_dv;
	logic [2:0][NW-1:0] num_nx, num_dv;
	logic [2:0]         neg_nx, neg_dv;
	logic [W-1:0]       den_nx, den_dv;

	always_comb begin
		carry_t       cs;
		nar_t         mn;
		logic         dv;
		logic [W-1:0] fabs;
		logic [W-1:0] vabs;
		cs   = sc_q[W];
		dv   = (cs.op == OP_DIVIDE);
		fabs = cs.f[W-1] ? (~cs.f + 1'b1) : cs.f;
		mn   = clip_mag(1'b0, SW'(root));
		cd_nx = cs;
		if (dv) begin
			den_nx   = fabs;
			cd_nx.dz = (cs.f == '0);
		end else begin
			den_nx   = root;
			cd_nx.dz = ((cs.op == OP_NORM) || (cs.op == OP_PERP)) && (root == '0);
		end
		if (cs.op == OP_MAG) begin
			cd_nx.scalar = mn.val;
			cd_nx.sat    = cs.sat || mn.sat;
		end
		for (int i = 0; i < 3; i++) begin
			vabs      = cs.v[i][W-1] ? (~cs.v[i] + 1'b1) : cs.v[i];
			num_nx[i] = {vabs, {F{1'b0}}};
			neg_nx[i] = cs.v[i][W-1] ^ (dv && cs.f[W-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_dv   <= cd_nx;
			num_dv <= num_nx;
			neg_dv <= neg_nx;
			den_dv <= den_nx;
		end
	end

	nar_t   qres [3];
	carry_t dc_q [1:NW];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vmu_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_dv[i]),
			.den (den_dv),
			.neg (neg_dv[i]),
			.res (qres[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_q[1] <= c_dv;
			for (int k = 1; k < NW; k++) begin
				dc_q[k+1] <= dc_q[k];
			end
		end
	end

	// Output register.
	logic [4*W-1:0] out_nx, out_q;
	logic [1:0]     flag_nx, flag_q;

	always_comb begin
		carry_t cf;
		logic   usediv;
		logic   qsat;
		cf     = dc_q[NW];
		usediv = (cf.op == OP_DIVIDE) || (cf.op == OP_NORM) || (cf.op == OP_PERP);
		qsat   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (usediv) begin
				out_nx[i*W +: W] = cf.dz ? '0 : qres[i].val;
				qsat = qsat || qres[i].sat;
			end else begin
				// Magnitude carries the input vector along but reports only the scalar.
				out_nx[i*W +: W] = (cf.op == OP_MAG) ? '0 : cf.v[i];
			end
		end
		out_nx[3*W +: W] = cf.scalar;
		flag_nx[0] = cf.dz;
		flag_nx[1] = cf.sat || (usediv && !cf.dz && qsat);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q  <= out_nx;
			flag_q <= flag_nx;
		end
	end

	assign m_axis_tdata = out_q;
	assign m_axis_tuser = flag_q;

	`VMU_ASSERT_IMPL(a_dz_vec_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[3*W-1:0] == '0, "div_zero with a nonzero vector")
	`VMU_ASSERT_IMPL(a_dz_scalar_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[4*W-1:3*W] == '0, "div_zero with a nonzero scalar")
	`VMU_ASSERT_NEXT(a_stall_hold, !en, vld_q == $past(vld_q), "pipeline moved during a stall")

endmodule
`default_nettype wire

FILE: rtl/core/vmu_lane.sv
`default_nettype none
module vmu_lane import vmu_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  func_t                  op,
	input  logic signed [W-1:0]    ai,
	input  logic signed [W-1:0]    bi,
	input  logic signed [W-1:0]    a1,
	input  logic signed [W-1:0]    a2,
	input  logic signed [W-1:0]    b1,
	input  logic signed [W-1:0]    b2,
	input  logic signed [W-1:0]    t1,
	input  logic signed [W-1:0]    t2,
	input  logic signed [W-1:0]    f,
	output logic signed [W-1:0]    v_s4,
	output logic [PW-1:0]          sq_s4,
	output logic signed [PW-1:0]   dp_s4,
	output logic                   sat_s4
);

	logic signed [W-1:0]  m0, m1, m2, m3;
	logic signed [PW-1:0] p_s2, q_s2;
	logic signed [W:0]    sum_s2;
	logic signed [W-1:0]  ai_s2;
	func_t                op_s2;

	logic signed [W-1:0]  v_nx;
	logic                 sat_nx;
	logic signed [W-1:0]  v_s3;
	logic                 sat_s3;
	logic signed [PW-1:0] dp_s3;

	always_comb begin
		m0 = '0;
		m1 = '0;
		m2 = '0;
		m3 = '0;
		case (op)
			OP_SCALE: begin
				m0 = ai;
				m1 = f;
			end
			OP_DOT: begin
				m0 = ai;
				m1 = bi;
			end
			OP_CROSS: begin
				m0 = a1;
				m1 = b2;
				m2 = a2;
				m3 = b1;
			end
			OP_PERP: begin
				m0 = t1;
				m1 = a2;
				m2 = t2;
				m3 = a1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= m0 * m1;
			q_s2   <= m2 * m3;
			sum_s2 <= (op == OP_SUB) ? ai - bi : ai + bi;
			ai_s2  <= ai;
			op_s2  <= op;
		end
	end

	always_comb begin
		nar_t nr;
		nr = '0;
		case (op_s2)
			OP_ADD, OP_SUB: nr = narrow(SW'(sum_s2), 1'b0);
			OP_SCALE:       nr = narrow(SW'(p_s2), 1'b1);
			OP_CROSS, OP_PERP: nr = narrow(SW'(p_s2) - SW'(q_s2), 1'b1);
			OP_DIVIDE, OP_MAG, OP_NORM: nr.val = ai_s2;
			default: nr = '0;
		endcase
		v_nx   = nr.val;
		sat_nx = nr.sat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3   <= v_nx;
			sat_s3 <= sat_nx;
			dp_s3  <= p_s2;
			v_s4   <= v_s3;
			sq_s4  <= PW'(PW'(v_s3) * PW'(v_s3));
			dp_s4  <= dp_s3;
			sat_s4 <= sat_s3;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/vmu_sqrt.sv
`default_nettype none
module vmu_sqrt import vmu_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [PW-1:0] rad,
	output logic [W-1:0]  root
);

	localparam int RW = W + 4;

	// One root bit per stage, two radicand bits consumed per stage.
	logic [PW-1:0] x_q [1:W];
	logic [RW-1:0] r_q [1:W];
	logic [W-1:0]  q_q [1:W];

	logic [PW-1:0] xs [0:W-1];
	logic [RW-1:0] rsrc [0:W-1];
	logic [W-1:0]  qs [0:W-1];
	logic [PW-1:0] nx [0:W-1];
	logic [RW-1:0] nr [0:W-1];
	logic [W-1:0]  nq [0:W-1];

	always_comb begin
		logic [RW-1:0] rs;
		logic [RW-1:0] tr;
		xs[0]   = rad;
		rsrc[0] = '0;
		qs[0]   = '0;
		for (int k = 1; k < W; k++) begin
			xs[k]   = x_q[k];
			rsrc[k] = r_q[k];
			qs[k]   = q_q[k];
		end
		for (int k = 0; k < W; k++) begin
			rs = {rsrc[k][RW-3:0], xs[k][PW-1 -: 2]};
			tr = {{(RW-W-2){1'b0}}, qs[k], 2'b01};
			nx[k] = xs[k] << 2;
			if (rs >= tr) begin
				nr[k] = rs - tr;
				nq[k] = {qs[k][W-2:0], 1'b1};
			end else begin
				nr[k] = rs;
				nq[k] = {qs[k][W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < W; k++) begin
				x_q[k+1] <= nx[k];
				r_q[k+1] <= nr[k];
				q_q[k+1] <= nq[k];
			end
		end
	end

	assign root = q_q[W];

endmodule
`default_nettype wire

FILE: rtl/core/vmu_div.sv
`default_nettype none
module vmu_div import vmu_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [W-1:0]  den,
	input  logic          neg,
	output nar_t          res
);

	// Restoring division, one quotient bit per stage.
	logic [NW-1:0] n_q [1:NW];
	logic [W-1:0]  r_q [1:NW];
	logic [NW-1:0] q_q [1:NW];
	logic [W-1:0]  d_q [1:NW];
	logic          g_q [1:NW];

	logic [NW-1:0] ns [0:NW-1];
	logic [W-1:0]  rsrc [0:NW-1];
	logic [NW-1:0] qs [0:NW-1];
	logic [W-1:0]  ds [0:NW-1];
	logic          gs [0:NW-1];
	logic [W-1:0]  nr [0:NW-1];
	logic [NW-1:0] nq [0:NW-1];

	always_comb begin
		logic [W:0] rs;
		ns[0]   = num;
		rsrc[0] = '0;
		qs[0]   = '0;
		ds[0]   = den;
		gs[0]   = neg;
		for (int k = 1; k < NW; k++) begin
			ns[k]   = n_q[k];
			rsrc[k] = r_q[k];
			qs[k]   = q_q[k];
			ds[k]   = d_q[k];
			gs[k]   = g_q[k];
		end
		for (int k = 0; k < NW; k++) begin
			rs = {rsrc[k], ns[k][NW-1]};
			if (rs >= {1'b0, ds[k]}) begin
				nr[k] = W'(rs - {1'b0, ds[k]});
				nq[k] = {qs[k][NW-2:0], 1'b1};
			end else begin
				nr[k] = rs[W-1:0];
				nq[k] = {qs[k][NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NW; k++) begin
				n_q[k+1] <= ns[k] << 1;
				r_q[k+1] <= nr[k];
				q_q[k+1] <= nq[k];
				d_q[k+1] <= ds[k];
				g_q[k+1] <= gs[k];
			end
		end
	end

	assign res = clip_mag(g_q[NW], SW'(q_q[NW]));

endmodule
`default_nettype wire

FILE: tb/vector3_math_unit_core_checker.sv
`default_nettype none
module vector3_math_unit_core_checker import vmu_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_axis_tvalid,
	input  wire logic           s_axis_tready,
	input  wire logic [7*W-1:0] s_axis_tdata,
	input  wire logic [3:0]     s_axis_tuser,
	input  wire logic           m_axis_tvalid,
	input  wire logic           m_axis_tready,
	input  wire logic [4*W-1:0] m_axis_tdata,
	input  wire logic [1:0]     m_axis_tuser,
	output int                  fail_count,
	output int                  pending
);

	typedef logic signed [129:0] wide_t;
	typedef logic signed [63:0] sval_t;
	typedef sval_t vec_t [3];

	typedef struct {
		comp_t rx;
		comp_t ry;
		comp_t rz;
		comp_t scalar_out;
		logic  div_zero;
		logic  saturated;
	} vec_result_t;

	vec_result_t expected_results[$];

	function automatic comp_t clip_to(bit neg, logic [129:0] mag, inout bit sat);
		logic [129:0] lim;
		lim = 130'h7FFF_FFFF + 130'(neg);
		if (mag > lim) begin
			sat = 1'b1;
			mag = lim;
		end
		return neg ? comp_t'(-mag[W-1:0]) : mag[W-1:0];
	endfunction

	// Round toward zero by shifting the magnitude, then saturate.
	function automatic comp_t shrink(wide_t v, int unsigned sh, inout bit sat);
		logic [129:0] mag;
		mag = v[129] ? 130'(-v) : 130'(v);
		return clip_to(v[129], mag >> sh, sat);
	endfunction

	function automatic comp_t fixed_div(sval_t num, sval_t den, inout bit sat);
		logic [129:0] n;
		logic [129:0] d;
		n = 130'(num < 0 ? -num : num) << F;
		d = 130'(den < 0 ? -den : den);
		return clip_to((num < 0) != (den < 0), n / d, sat);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [129:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (130'(c) * 130'(c) <= s) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] vec_length(vec_t v);
		wide_t s;
		s = wide_t'(v[0]) * wide_t'(v[0]) + wide_t'(v[1]) * wide_t'(v[1])
			+ wide_t'(v[2]) * wide_t'(v[2]);
		return int_sqrt(130'(s));
	endfunction

	function automatic vec_t cross_prod(vec_t a, vec_t b, inout bit sat);
		vec_t r;
		r[0] = sval_t'($signed(shrink(wide_t'(a[1]) * wide_t'(b[2])
			- wide_t'(a[2]) * wide_t'(b[1]), F, sat)));
		r[1] = sval_t'($signed(shrink(wide_t'(a[2]) * wide_t'(b[0])
			- wide_t'(a[0]) * wide_t'(b[2]), F, sat)));
		r[2] = sval_t'($signed(shrink(wide_t'(a[0]) * wide_t'(b[1])
			- wide_t'(a[1]) * wide_t'(b[0]), F, sat)));
		return r;
	endfunction

	function automatic void unit_vec(vec_t v, inout vec_result_t res, inout bit dz,
			inout bit sat);
		logic [63:0] m;
		m = vec_length(v);
		if (m == 0) begin
			dz = 1'b1;
			return;
		end
		res.rx = fixed_div(v[0], sval_t'(m), sat);
		res.ry = fixed_div(v[1], sval_t'(m), sat);
		res.rz = fixed_div(v[2], sval_t'(m), sat);
	endfunction

	function automatic vec_result_t vector_op(logic [3:0] fn, logic [7*W-1:0] d);
		vec_result_t res;
		vec_t a;
		vec_t b;
		vec_t t;
		vec_t c;
		vec_t r;
		sval_t f;
		bit dz;
		bit sat;
		int idx;
		dz = 0;
		sat = 0;
		res = '{default: '0};
		for (int i = 0; i < 3; i++) begin
			a[i] = sval_t'($signed(d[i*W +: W]));
			b[i] = sval_t'($signed(d[(i+3)*W +: W]));
			r[i] = 0;
		end
		f = sval_t'($signed(d[6*W +: W]));
		case (fn)
			OP_ADD: for (int i = 0; i < 3; i++) r[i] =
				sval_t'($signed(shrink(wide_t'(a[i] + b[i]), 0, sat)));
			OP_SUB: for (int i = 0; i < 3; i++) r[i] =
				sval_t'($signed(shrink(wide_t'(a[i] - b[i]), 0, sat)));
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] =
				sval_t'($signed(shrink(wide_t'(a[i]) * wide_t'(f), F, sat)));
			OP_DIVIDE: begin
				if (f == 0) dz = 1;
				else for (int i = 0; i < 3; i++) r[i] = sval_t'($signed(fixed_div(a[i], f, sat)));
			end
			OP_DOT: res.scalar_out = shrink(wide_t'(a[0]) * wide_t'(b[0])
				+ wide_t'(a[1]) * wide_t'(b[1]) + wide_t'(a[2]) * wide_t'(b[2]), F, sat);
			OP_CROSS: r = cross_prod(a, b, sat);
			OP_MAG: res.scalar_out = clip_to(1'b0, 130'(vec_length(a)), sat);
			OP_PERP: begin
				t = a;
				idx = a[0] < a[1] ? (a[0] < a[2] ? 0 : 2) : (a[1] < a[2] ? 1 : 2);
				t[idx] = sval_t'(1) << F;
				c = cross_prod(t, a, sat);
				unit_vec(c, res, dz, sat);
			end
			OP_NORM: unit_vec(a, res, dz, sat);
			default: ;
		endcase
		if (fn inside {OP_ADD, OP_SUB, OP_SCALE, OP_DIVIDE, OP_CROSS}) begin
			res.rx = r[0][W-1:0];
			res.ry = r[1][W-1:0];
			res.rz = r[2][W-1:0];
		end
		res.div_zero = dz;
		res.saturated = sat;
		return res;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		vec_result_t exp_r;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(vector_op(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no input waiting");
					errs++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tdata[0 +: W] !== exp_r.rx) begin
						$error("rx expected %h actual %h", exp_r.rx, m_axis_tdata[0 +: W]);
						errs++;
					end
					if (m_axis_tdata[W +: W] !== exp_r.ry) begin
						$error("ry expected %h actual %h", exp_r.ry, m_axis_tdata[W +: W]);
						errs++;
					end
					if (m_axis_tdata[2*W +: W] !== exp_r.rz) begin
						$error("rz expected %h actual %h", exp_r.rz, m_axis_tdata[2*W +: W]);
						errs++;
					end
					if (m_axis_tdata[3*W +: W] !== exp_r.scalar_out) begin
						$error("scalar_out expected %h actual %h", exp_r.scalar_out,
							m_axis_tdata[3*W +: W]);
						errs++;
					end
					if (m_axis_tuser[0] !== exp_r.div_zero) begin
						$error("div_zero expected %b actual %b", exp_r.div_zero, m_axis_tuser[0]);
						errs++;
					end
					if (m_axis_tuser[1] !== exp_r.saturated) begin
						$error("saturated expected %b actual %b", exp_r.saturated,
							m_axis_tuser[1]);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule
`default_nettype wire

FILE: tb/vector3_math_unit_core_tb.sv
`default_nettype none
module vector3_math_unit_core_tb import vmu_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 300;

	logic           clk;
	logic           arst_n;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	logic [7*W-1:0] s_axis_tdata;
	logic [3:0]     s_axis_tuser;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [4*W-1:0] m_axis_tdata;
	logic [1:0]     m_axis_tuser;
	int             fail_count;
	int             pending;
	int             cycle_count = 0;
	int             sent;
	int             send_idle_pct;
	int             recv_idle_pct;
	logic           recv_hold = 1'b0;

	vector3_math_unit_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	vector3_math_unit_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vector3_math_unit_core_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (recv_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
	end

	task automatic send_vec(logic [3:0] fn, comp_t ax, comp_t ay, comp_t az, comp_t bx,
			comp_t by, comp_t bz, comp_t factor);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {factor, bz, by, bx, az, ay, ax};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// A mix of full-range values, values of moderate size so that results land inside range, and corner values.
	function automatic comp_t rand_comp();
		case ($urandom_range(4))
			0, 1: return $urandom;
			2: return comp_t'($signed($urandom_range(2 * (1 << 20))) - (1 << 20));
			3: return comp_t'($signed($urandom_range(2 * (1 << 17))) - (1 << 17));
			default: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return '0;
					3: return 32'h0001_0000;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic send_random(int count);
		logic [3:0] fn;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(19) == 0) ? 4'($urandom_range(15, OP_PERP + 1))
				: 4'($urandom_range(OP_PERP));
			send_vec(fn, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
				rand_comp(), ($urandom_range(15) == 0) ? comp_t'(0) : rand_comp());
		end
	endtask

	initial begin
		// The receiver stops for a long stretch while the sender keeps offering.
		wait (sent == 300);
		recv_hold <= 1'b1;
		repeat (400) @(posedge clk);
		recv_hold <= 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int fn = OP_ADD; fn <= OP_PERP; fn++) begin
			send_vec(4'(fn), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
			send_vec(4'(fn), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		end
		send_vec(OP_DIVIDE, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, '0, '0, '0, '0);
		send_vec(OP_NORM, '0, '0, '0, '0, '0, '0, '0);
		send_vec(OP_PERP, '0, '0, '0, '0, '0, '0, '0);
		send_vec(OP_NORM, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
		send_vec(OP_PERP, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0, '0);
		for (int fn = OP_PERP + 1; fn <= 15; fn++)
			send_vec(4'(fn), '1, '1, '1, '1, '1, '1, '1);

		// Pause until everything in flight has come out.
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 45;
		send_random(480);
		send_idle_pct = 45;
		recv_idle_pct = 31;
		send_random(480);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(480);
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("vector3_math_unit_core_tb passed");
		else
			$display("vector3_math_unit_core_tb failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/vmu_pkg.sv
rtl/core/vmu_lane.sv
rtl/core/vmu_sqrt.sv
rtl/core/vmu_div.sv
rtl/core/vector3_math_unit_core.sv
tb/vector3_math_unit_core_checker.sv
tb/vector3_math_unit_core_tb.sv
